// ===== rtl/bpfa_pkg.sv =====
// Package for the bitmap page frame allocator.
// Holds operation codes, sequencer states, reset constants and counter helpers.
// No dependencies.
`default_nettype none

package bpfa_pkg;

    localparam int OP_W       = 3;
    localparam int PAGE_W     = 15;
    localparam int COUNT_W    = 16;
    localparam int POS_MIN_W  = 17;

    localparam int NUM_PAGES_DEF     = 32768;
    localparam int MAP_WORD_BITS_DEF = 64;

    localparam logic [COUNT_W-1:0] TOTAL_PAGES_RESET = 16'd32768;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST   = 3'd0,
        OP_LOCK      = 3'd1,
        OP_FREE      = 3'd2,
        OP_RESERVE   = 3'd3,
        OP_UNRESERVE = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_EVAL,
        ST_APPLY,
        ST_DONE
    } t_state;

    typedef logic [COUNT_W-1:0] t_count;

    function automatic t_count sat_inc(input t_count c, input t_count d);
        logic [COUNT_W:0] s;
        s = {1'b0, c} + {1'b0, d};
        return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

    function automatic t_count sat_dec(input t_count c, input t_count d);
        return (c < d) ? '0 : (c - d);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bitmap_page_frame_allocator_top.sv =====
// Bitmap page frame allocator: first-fit page request, run updates and map clear over a page map.
// Uses bpfa_pkg for codes, states and saturating counter helpers.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | input     | i_in_valid / o_in_stall | i_operation, i_page_index, i_page_count
//   out     | output    | o_out_valid/ i_out_stall| o_result_page, o_found, o_out_of_range,
//           |           |                         | o_free_pages, o_used_pages,
//           |           |                         | o_reserved_pages
//   cfg     | input     | i_cfg_we                | i_cfg_wdata (total_pages)
//
// Request: each map word is read and then evaluated, up to the first free page.
// Lock/free/reserve/unreserve: each map word of the run inside the page limit is read,
// evaluated and written back, then applied to the counters; a run with no page inside
// the limit and an unused code go straight to the result. Clear: one map word per cycle
// is zeroed; the map memory is single-port and the mask/popcount unit is shared.
// After reset a sweep of one map word per cycle zeroes the map; o_in_stall is high
// meanwhile. One request is worked on at a time and o_in_stall stays high until its
// result moves to the output register, which waits while an older result is stalled.
`default_nettype none

module bitmap_page_frame_allocator_top #(
    parameter int NUM_PAGES     = bpfa_pkg::NUM_PAGES_DEF,
    parameter int MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_cfg_we,
    input  wire logic [bpfa_pkg::COUNT_W-1:0] i_cfg_wdata,

    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [bpfa_pkg::OP_W-1:0]    i_operation,
    input  wire logic [bpfa_pkg::PAGE_W-1:0]  i_page_index,
    input  wire logic [bpfa_pkg::COUNT_W-1:0] i_page_count,

    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [bpfa_pkg::PAGE_W-1:0]       o_result_page,
    output logic                              o_found,
    output logic                              o_out_of_range,
    output logic [bpfa_pkg::COUNT_W-1:0]      o_free_pages,
    output logic [bpfa_pkg::COUNT_W-1:0]      o_used_pages,
    output logic [bpfa_pkg::COUNT_W-1:0]      o_reserved_pages
);

    localparam int BW    = $clog2(MAP_WORD_BITS + 1) - 1;
    localparam int WW    = 1 << BW;
    localparam int DEPTH = (NUM_PAGES + WW - 1) / WW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (AW + BW > bpfa_pkg::POS_MIN_W) ? (AW + BW) : bpfa_pkg::POS_MIN_W;
    localparam int PW    = CW - BW;
    localparam int DW    = BW + 1;

    localparam logic [bpfa_pkg::COUNT_W-1:0] FREE_RESET =
        (int'(bpfa_pkg::TOTAL_PAGES_RESET) < NUM_PAGES) ?
        bpfa_pkg::TOTAL_PAGES_RESET : bpfa_pkg::COUNT_W'(NUM_PAGES);

    logic [WW-1:0] mem [DEPTH];

    bpfa_pkg::t_state r_state, n_state;
    bpfa_pkg::t_op    r_op, n_op;
    logic [PW-1:0]    r_wpos, n_wpos;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [WW-1:0]    r_rdata;
    logic [DW-1:0]    r_delta, n_delta;
    logic [CW-1:0]    r_page, n_page;
    logic             r_found, n_found;
    logic             r_oor, n_oor;
    bpfa_pkg::t_count r_total, n_total;
    bpfa_pkg::t_count r_free, n_free;
    bpfa_pkg::t_count r_used, n_used;
    bpfa_pkg::t_count r_rsvd, n_rsvd;

    logic                         r_out_valid, n_out_valid;
    logic [bpfa_pkg::PAGE_W-1:0]  r_o_page;
    logic                         r_o_found;
    logic                         r_o_oor;
    bpfa_pkg::t_count             r_o_free;
    bpfa_pkg::t_count             r_o_used;
    bpfa_pkg::t_count             r_o_rsvd;

    logic                         mem_we;
    logic [WW-1:0]                mem_wd;
    logic                         out_load;

    bpfa_pkg::t_count             limit;
    logic [CW-1:0]                limit_c;
    logic [CW-1:0]                end_pg;
    logic [CW-1:0]                eff_end;
    logic [CW-1:0]                first_c;
    logic [CW-1:0]                wbase;
    logic [CW-1:0]                next_base;
    logic [CW-1:0]                hi_diff;
    logic [DW-1:0]                hi_off;
    logic [BW-1:0]                lo_off;
    logic [WW-1:0]                win;
    logic [WW-1:0]                cand;
    logic [WW-1:0]                onehot;
    logic [BW-1:0]                hit_idx;
    logic                         set_op;
    logic [WW-1:0]                chg;
    logic [DW-1:0]                pc_tree [WW];
    bpfa_pkg::t_count             delta16;

    // page limit and request fields
    always_comb begin
        limit     = (int'(r_total) < NUM_PAGES) ? r_total : bpfa_pkg::COUNT_W'(NUM_PAGES);
        limit_c   = CW'(limit);
        first_c   = CW'(i_page_index);
        end_pg    = first_c + CW'(i_page_count);
        eff_end   = (end_pg < limit_c) ? end_pg : limit_c;
    end

    // shared word unit: window mask, first-fit pick, change mask
    always_comb begin
        wbase     = {r_wpos, {BW{1'b0}}};
        next_base = wbase + CW'(WW);
        hi_diff   = r_hi - wbase;
        hi_off    = (hi_diff >= CW'(WW)) ? DW'(WW) : hi_diff[DW-1:0];
        lo_off    = (r_wpos == r_lo[CW-1:BW]) ? r_lo[BW-1:0] : '0;
        for (int b = 0; b < WW; b++) begin
            win[b] = (DW'(b) >= {1'b0, lo_off}) && (DW'(b) < hi_off);
        end
        cand    = ~r_rdata & win;
        onehot  = cand & (~cand + WW'(1));
        hit_idx = '0;
        for (int b = 0; b < WW; b++) begin
            if (onehot[b]) begin
                hit_idx = hit_idx | BW'(b);
            end
        end
        set_op = r_op inside {bpfa_pkg::OP_LOCK, bpfa_pkg::OP_RESERVE};
        chg    = set_op ? (win & ~r_rdata) : (win & r_rdata);
    end

    // popcount of the change mask as a log-depth tree
    always_comb begin
        for (int i = 0; i < WW; i++) begin
            pc_tree[i] = DW'(chg[i]);
        end
        for (int lvl = 1; lvl < WW; lvl = lvl * 2) begin
            for (int i = 0; i + lvl < WW; i = i + 2 * lvl) begin
                pc_tree[i] = pc_tree[i] + pc_tree[i + lvl];
            end
        end
    end

    assign delta16 = bpfa_pkg::COUNT_W'(r_delta);

    // sequencer: next state and datapath control
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_wpos  = r_wpos;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_delta = r_delta;
        n_page  = r_page;
        n_found = r_found;
        n_oor   = r_oor;
        n_total = i_cfg_we ? i_cfg_wdata : r_total;
        n_free  = r_free;
        n_used  = r_used;
        n_rsvd  = r_rsvd;
        mem_we  = 1'b0;
        mem_wd  = r_rdata;
        out_load = 1'b0;

        case (r_state)
            bpfa_pkg::ST_INIT, bpfa_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = '0;
                if (r_wpos == PW'(DEPTH - 1)) begin
                    n_wpos  = '0;
                    n_state = (r_state == bpfa_pkg::ST_INIT) ? bpfa_pkg::ST_IDLE
                                                             : bpfa_pkg::ST_DONE;
                end else begin
                    n_wpos = r_wpos + PW'(1);
                end
            end
            bpfa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = bpfa_pkg::t_op'(i_operation);
                    n_page  = '0;
                    n_found = 1'b0;
                    n_oor   = 1'b0;
                    n_state = bpfa_pkg::ST_DONE;
                    case (bpfa_pkg::t_op'(i_operation))
                        bpfa_pkg::OP_REQUEST: begin
                            n_lo   = '0;
                            n_hi   = limit_c;
                            n_wpos = '0;
                            if (limit != '0) begin
                                n_state = bpfa_pkg::ST_READ;
                            end
                        end
                        bpfa_pkg::OP_LOCK, bpfa_pkg::OP_FREE,
                        bpfa_pkg::OP_RESERVE, bpfa_pkg::OP_UNRESERVE: begin
                            n_oor  = (i_page_count != '0) && (end_pg > limit_c);
                            n_lo   = first_c;
                            n_hi   = eff_end;
                            n_wpos = first_c[CW-1:BW];
                            if (first_c < eff_end) begin
                                n_state = bpfa_pkg::ST_READ;
                            end
                        end
                        bpfa_pkg::OP_CLEAR: begin
                            n_free  = limit;
                            n_used  = '0;
                            n_rsvd  = '0;
                            n_wpos  = '0;
                            n_state = bpfa_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_state = bpfa_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bpfa_pkg::ST_READ: begin
                n_state = bpfa_pkg::ST_EVAL;
            end
            bpfa_pkg::ST_EVAL: begin
                if (r_op == bpfa_pkg::OP_REQUEST) begin
                    if (cand != '0) begin
                        mem_we  = 1'b1;
                        mem_wd  = r_rdata | onehot;
                        n_page  = wbase | CW'(hit_idx);
                        n_found = 1'b1;
                        n_free  = bpfa_pkg::sat_dec(r_free, bpfa_pkg::COUNT_W'(1));
                        n_used  = bpfa_pkg::sat_inc(r_used, bpfa_pkg::COUNT_W'(1));
                        n_state = bpfa_pkg::ST_DONE;
                    end else if (next_base >= r_hi) begin
                        n_state = bpfa_pkg::ST_DONE;
                    end else begin
                        n_wpos  = r_wpos + PW'(1);
                        n_state = bpfa_pkg::ST_READ;
                    end
                end else begin
                    mem_we  = 1'b1;
                    mem_wd  = set_op ? (r_rdata | chg) : (r_rdata & ~chg);
                    n_delta = pc_tree[0];
                    n_state = bpfa_pkg::ST_APPLY;
                end
            end
            bpfa_pkg::ST_APPLY: begin
                case (r_op)
                    bpfa_pkg::OP_LOCK: begin
                        n_free = bpfa_pkg::sat_dec(r_free, delta16);
                        n_used = bpfa_pkg::sat_inc(r_used, delta16);
                    end
                    bpfa_pkg::OP_RESERVE: begin
                        n_free = bpfa_pkg::sat_dec(r_free, delta16);
                        n_rsvd = bpfa_pkg::sat_inc(r_rsvd, delta16);
                    end
                    bpfa_pkg::OP_FREE: begin
                        n_free = bpfa_pkg::sat_inc(r_free, delta16);
                        n_used = bpfa_pkg::sat_dec(r_used, delta16);
                    end
                    bpfa_pkg::OP_UNRESERVE: begin
                        n_free = bpfa_pkg::sat_inc(r_free, delta16);
                        n_rsvd = bpfa_pkg::sat_dec(r_rsvd, delta16);
                    end
                    default: begin
                        n_free = r_free;
                    end
                endcase
                if (next_base >= r_hi) begin
                    n_state = bpfa_pkg::ST_DONE;
                end else begin
                    n_wpos  = r_wpos + PW'(1);
                    n_state = bpfa_pkg::ST_READ;
                end
            end
            bpfa_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = bpfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bpfa_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpfa_pkg::ST_INIT;
            r_op        <= bpfa_pkg::OP_REQUEST;
            r_wpos      <= '0;
            r_total     <= bpfa_pkg::TOTAL_PAGES_RESET;
            r_free      <= FREE_RESET;
            r_used      <= '0;
            r_rsvd      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_wpos      <= n_wpos;
            r_total     <= n_total;
            r_free      <= n_free;
            r_used      <= n_used;
            r_rsvd      <= n_rsvd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_delta <= n_delta;
        r_page  <= n_page;
        r_found <= n_found;
        r_oor   <= n_oor;
        if (out_load) begin
            r_o_page  <= r_page[bpfa_pkg::PAGE_W-1:0];
            r_o_found <= r_found;
            r_o_oor   <= r_oor;
            r_o_free  <= r_free;
            r_o_used  <= r_used;
            r_o_rsvd  <= r_rsvd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wpos[AW-1:0]] <= mem_wd;
        end
        r_rdata <= mem[r_wpos[AW-1:0]];
    end

    assign o_in_stall       = (r_state != bpfa_pkg::ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_result_page    = r_o_page;
    assign o_found          = r_o_found;
    assign o_out_of_range   = r_o_oor;
    assign o_free_pages     = r_o_free;
    assign o_used_pages     = r_o_used;
    assign o_reserved_pages = r_o_rsvd;

endmodule

`default_nettype wire
